@@ rtl/lsws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsws_pkg: shared definitions for the LIFO stack with search
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package lsws_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int POS_W     = 7;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_HIT       = 3'd4;

    typedef struct packed {
        logic push;
        logic pop;
        logic rot;
        logic srch;
    } cell_ctl_t;

endpackage

@@ rtl/lsws_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsws_cell: one stack cell
// Holds one entry, shifts with its neighbors on push, pop and rotate, and
// registers its own compare result on a search.
// ----------------------------------------------------------------------------
module lsws_cell #(
    parameter int DEPTH = lsws_pkg::DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsws_pkg::cell_ctl_t               ctl,
    input  logic [$clog2(DEPTH+1)-1:0]        occ,
    input  logic signed [lsws_pkg::VAL_W-1:0] key,
    input  logic signed [lsws_pkg::VAL_W-1:0] up_data,
    input  logic signed [lsws_pkg::VAL_W-1:0] dn_data,
    input  logic signed [lsws_pkg::VAL_W-1:0] wrap_data,
    output logic signed [lsws_pkg::VAL_W-1:0] data,
    output logic                              hit
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [lsws_pkg::VAL_W-1:0] data_reg;
    logic signed [lsws_pkg::VAL_W-1:0] data_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              valid;
    logic                              tail;

    assign valid = (occ > CNT_W'(INDEX));
    assign tail  = (occ == CNT_W'(INDEX + 1));

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = up_data;
        end
        else if (ctl.pop)
        begin
            data_next = dn_data;
        end
        else if (ctl.rot)
        begin
            data_next = tail ? wrap_data : dn_data;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.srch)
        begin
            hit_next = valid && (data_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

@@ rtl/lsws_prio.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsws_prio: first-match encoder
// Finds the lowest set bit of the cell hit vector in two levels of groups
// of eight.
// ----------------------------------------------------------------------------
module lsws_prio #(
    parameter int DEPTH = lsws_pkg::DEPTH_DEF
) (
    input  logic [DEPTH-1:0]         match,
    output logic                     found,
    output logic [$clog2(DEPTH)-1:0] idx
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int NG    = (DEPTH + 7) / 8;
    localparam int PW    = $clog2(NG * 8);

    logic [NG*8-1:0] pad;
    logic [NG-1:0]   g_any;
    logic [2:0]      g_sel [NG];
    logic [PW-1:0]   full;

    always_comb
    begin
        pad = '0;
        pad[DEPTH-1:0] = match;
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            g_any[g] = |pad[g*8 +: 8];
            g_sel[g] = 3'd0;
            for (int j = 7; j >= 0; j--)
            begin
                if (pad[g*8 + j])
                begin
                    g_sel[g] = 3'(j);
                end
            end
        end
    end

    always_comb
    begin
        full = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (g_any[g])
            begin
                full = PW'(g * 8) + PW'(g_sel[g]);
            end
        end
    end

    assign found = |g_any;
    assign idx   = full[IDX_W-1:0];

endmodule

@@ rtl/lifo_stack_with_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO of signed words with search and dump
// A row of cells, top entry in cell 0, shifts on push and pop; search uses a
// comparator in each cell, dump rotates the occupied cells past the top.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  command  cmd_valid / cmd_ready  op, value
//  response rsp_valid / rsp_ready  status, item_value, position, last
//
//  Push and pop: result registered at the command transfer.
//  Search: the cell compares register, then the first match is
//  encoded into the response register.
//  Dump: one response per cycle per stored entry while the response is taken, driven by the cell ring.
//  A stalled response holds the block; commands wait until it is free.
//  Reset empties the stack; cell contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
    parameter int DEPTH = lsws_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  logic [lsws_pkg::OP_W-1:0]          op,
    input  logic signed [lsws_pkg::VAL_W-1:0]  value,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [lsws_pkg::ST_W-1:0]          status,
    output logic signed [lsws_pkg::VAL_W-1:0]  item_value,
    output logic [lsws_pkg::POS_W-1:0]         position,
    output logic                               last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  occ_reg, occ_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic signed [lsws_pkg::VAL_W-1:0] key_reg, key_next;
    logic                              out_valid_reg, out_valid_next;
    logic [lsws_pkg::ST_W-1:0]         status_reg, status_next;
    logic signed [lsws_pkg::VAL_W-1:0] item_reg, item_next;
    logic [lsws_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic                              last_reg, last_next;

    logic                              slot_free;
    logic                              cmd_fire;
    logic                              is_empty;
    logic                              is_full;
    lsws_pkg::cell_ctl_t               ctl;
    logic signed [lsws_pkg::VAL_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]                  cell_hit;
    logic                              found;
    logic [IDX_W-1:0]                  found_idx;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE) && slot_free;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign is_empty  = (occ_reg == '0);
    assign is_full   = (occ_reg == CNT_W'(DEPTH));

    assign ctl.push = cmd_fire && (op == lsws_pkg::OP_PUSH) && !is_full;
    assign ctl.pop  = cmd_fire && (op == lsws_pkg::OP_POP) && !is_empty;
    assign ctl.srch = cmd_fire && (op == lsws_pkg::OP_SEARCH);
    assign ctl.rot  = (state_reg == S_DUMP) && slot_free;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [lsws_pkg::VAL_W-1:0] up_d;
        logic signed [lsws_pkg::VAL_W-1:0] dn_d;

        if (i == 0)
        begin : g_top
            assign up_d = value;
        end
        else
        begin : g_mid
            assign up_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign dn_d = '0;
        end
        else
        begin : g_inner
            assign dn_d = cell_data[i+1];
        end

        lsws_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .occ       (occ_reg),
            .key       (value),
            .up_data   (up_d),
            .dn_data   (dn_d),
            .wrap_data (cell_data[0]),
            .data      (cell_data[i]),
            .hit       (cell_hit[i])
        );
    end

    lsws_prio #(
        .DEPTH (DEPTH)
    ) u_prio (
        .match (cell_hit),
        .found (found),
        .idx   (found_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        status_next    = status_reg;
        item_next      = item_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lsws_pkg::ST_DONE;
                    item_next      = '0;
                    pos_next       = '0;
                    last_next      = 1'b1;
                    case (op)
                        lsws_pkg::OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = lsws_pkg::ST_FULL;
                            end
                            else
                            begin
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        lsws_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = lsws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        lsws_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                status_next = lsws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                key_next       = value;
                                state_next     = S_SRCH;
                            end
                        end
                        lsws_pkg::OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                status_next = lsws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                cnt_next       = CNT_W'(1);
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            status_next = lsws_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (found)
                    begin
                        status_next = lsws_pkg::ST_HIT;
                        item_next   = key_reg;
                        pos_next    = lsws_pkg::POS_W'(found_idx) + 1'b1;
                    end
                    else
                    begin
                        status_next = lsws_pkg::ST_NOT_FOUND;
                        item_next   = '0;
                        pos_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lsws_pkg::ST_HIT;
                    item_next      = cell_data[0];
                    pos_next       = lsws_pkg::POS_W'(cnt_reg);
                    last_next      = (cnt_reg == occ_reg);
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == occ_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign item_value = item_reg;
    assign position   = pos_reg;
    assign last       = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_dump_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> (occ_reg == $past(occ_reg)))
        else $error("occupancy changed during dump");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("push did not grow the stack");

    a_dump_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP && slot_free && cnt_reg == occ_reg)
            |=> (last_reg && pos_reg == lsws_pkg::POS_W'($past(occ_reg))))
        else $error("dump final position does not match occupancy");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH && slot_free && found)
            |-> (CNT_W'(found_idx) < occ_reg))
        else $error("search hit beyond stack top");

endmodule
